>>> src/fat_short_name_generator_assert.svh
`ifndef FAT_SHORT_NAME_GENERATOR_ASSERT_SVH
`define FAT_SHORT_NAME_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off in reset
`define FSNG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsng check failed");

// next-cycle implication, sampled on clk, off in reset
`define FSNG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsng check failed");

`endif

>>> src/fsng_pkg.sv
package fsng_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] pos_t;

  localparam int SN_LEN    = 11;
  localparam int BASE_MAX  = 8;
  localparam int EXT_MAX   = 3;
  localparam int BASE_KEEP = 6;

  localparam pos_t POS_LAST = pos_t'(SN_LEN - 1);
  localparam pos_t POS_TILDE = pos_t'(BASE_KEEP);
  localparam pos_t POS_ONE   = pos_t'(BASE_KEEP + 1);
  localparam pos_t POS_EXT   = pos_t'(BASE_MAX);

  localparam byte_t CHAR_SPACE = 8'h20;
  localparam byte_t CHAR_DOT   = 8'h2E;
  localparam byte_t CHAR_UNDER = 8'h5F;
  localparam byte_t CHAR_TILDE = 8'h7E;
  localparam byte_t CHAR_ONE   = 8'h31;
  localparam byte_t CHAR_LOW_A = 8'h61;
  localparam byte_t CHAR_LOW_Z = 8'h7A;
  localparam byte_t CASE_GAP   = 8'h20;

  function automatic byte_t map_char(input byte_t c);
    byte_t r;
    case (c) inside
      8'h00, 8'h09, 8'h0A, 8'h0D, 8'h20, 8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F,
      8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: begin
        r = CHAR_UNDER;
      end
      default: begin
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
          r = c - CASE_GAP;
        end else begin
          r = c;
        end
      end
    endcase
    return r;
  endfunction

  function automatic byte_t rot_add(input byte_t sum, input byte_t b);
    return {sum[0], sum[7:1]} + b;
  endfunction

endpackage

>>> src/fsng_if.sv
interface fsng_char_if;
  logic               valid;
  logic               ready;
  fsng_pkg::byte_t    name_char;
  logic               last_char;

  modport source (output valid, name_char, last_char, input ready);
  modport sink   (input valid, name_char, last_char, output ready);
endinterface

interface fsng_short_if;
  logic               valid;
  logic               ready;
  fsng_pkg::byte_t    short_char;
  fsng_pkg::pos_t     position;
  fsng_pkg::byte_t    checksum;
  logic               last_result;

  modport source (output valid, short_char, position, checksum, last_result, input ready);
  modport sink   (input valid, short_char, position, checksum, last_result, output ready);
endinterface

>>> src/fat_short_name_generator.sv
// The first short-name word is registered once the final name word has set the flush flag
// and the output register is free; the 11 short-name words shift out of the name store
// one per cycle, and the store takes no name word during that flush.
// The flush stalls with the output register while its word is not taken.
// Reset: counters, flags and checksum clear, the name store fills with spaces.
module fat_short_name_generator (
  input  logic         clk,
  input  logic         rst,
  fsng_char_if.sink    chars,
  fsng_short_if.source sname
);

  fsng_pkg::byte_t sn [fsng_pkg::SN_LEN];
  logic [3:0]      base_count;
  logic [1:0]      ext_count;
  logic            dot_seen;
  logic            flushing;
  fsng_pkg::pos_t  idx;
  fsng_pkg::byte_t sum;

  logic            take;
  logic            load;
  logic            base_over;
  fsng_pkg::byte_t mapped;
  fsng_pkg::byte_t emit_byte;
  fsng_pkg::byte_t sum_next;
  logic            emit_last;

  assign chars.ready = !flushing;
  assign take        = chars.valid && !flushing;
  assign load        = flushing && (!sname.valid || sname.ready);
  assign base_over   = base_count > 4'(fsng_pkg::BASE_MAX);
  assign mapped      = fsng_pkg::map_char(chars.name_char);
  assign emit_last   = idx == fsng_pkg::POS_LAST;

  always_comb begin
    if (base_over && idx == fsng_pkg::POS_TILDE) begin
      emit_byte = fsng_pkg::CHAR_TILDE;
    end else if (base_over && idx == fsng_pkg::POS_ONE) begin
      emit_byte = fsng_pkg::CHAR_ONE;
    end else begin
      emit_byte = sn[0];
    end
    sum_next = fsng_pkg::rot_add(sum, emit_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsng_pkg::SN_LEN; i++) begin
        sn[i] <= fsng_pkg::CHAR_SPACE;
      end
      base_count  <= '0;
      ext_count   <= '0;
      dot_seen    <= 1'b0;
      flushing    <= 1'b0;
      idx         <= '0;
      sum         <= '0;
      sname.valid <= 1'b0;
    end else begin
      if (take) begin
        if (!dot_seen && chars.name_char == fsng_pkg::CHAR_DOT) begin
          dot_seen <= 1'b1;
        end else if (!dot_seen) begin
          if (base_count < 4'(fsng_pkg::BASE_MAX)) begin
            sn[base_count] <= mapped;
          end
          if (base_count <= 4'(fsng_pkg::BASE_MAX)) begin
            base_count <= base_count + 4'd1;
          end
        end else if (ext_count < 2'(fsng_pkg::EXT_MAX)) begin
          sn[fsng_pkg::POS_EXT + {2'b00, ext_count}] <= mapped;
          ext_count <= ext_count + 2'd1;
        end
        if (chars.last_char) begin
          flushing <= 1'b1;
        end
      end
      if (load) begin
        for (int i = 0; i < fsng_pkg::SN_LEN - 1; i++) begin
          sn[i] <= sn[i + 1];
        end
        sn[fsng_pkg::SN_LEN - 1] <= fsng_pkg::CHAR_SPACE;
        sname.valid       <= 1'b1;
        sname.short_char  <= emit_byte;
        sname.position    <= idx;
        sname.last_result <= emit_last;
        sname.checksum    <= emit_last ? sum_next : '0;
        if (emit_last) begin
          flushing   <= 1'b0;
          idx        <= '0;
          sum        <= '0;
          base_count <= '0;
          ext_count  <= '0;
          dot_seen   <= 1'b0;
        end else begin
          idx <= idx + 4'd1;
          sum <= sum_next;
        end
      end else if (sname.ready) begin
        sname.valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/fsng_checker.sv
`include "fat_short_name_generator_assert.svh"

module fsng_props (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input fsng_pkg::pos_t out_position,
  input fsng_pkg::byte_t out_checksum,
  input logic           out_last
);

  `FSNG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_position))
  `FSNG_ASSERT_NOW(a_last_pos, out_valid && out_last, out_position == fsng_pkg::POS_LAST)
  `FSNG_ASSERT_NOW(a_sum_zero, out_valid && !out_last, out_checksum == 8'd0 && !in_ready)
  `FSNG_ASSERT_NEXT(a_pos_step, out_valid && out_ready && !out_last,
    out_valid && out_position == 4'($past(out_position) + 4'd1))

endmodule

bind fat_short_name_generator fsng_props u_fsng_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (chars.ready),
  .out_valid    (sname.valid),
  .out_ready    (sname.ready),
  .out_position (sname.position),
  .out_checksum (sname.checksum),
  .out_last     (sname.last_result)
);

>>> tb/fsng_checker.sv
module fsng_checker (
  input  logic  clk,
  input  logic  rst,
  fsng_char_if  chars,
  fsng_short_if sname,
  output int    errors,
  output int    open_count
);

  typedef struct packed {
    fsng_pkg::byte_t short_char;
    fsng_pkg::pos_t  position;
    fsng_pkg::byte_t checksum;
    logic            last_result;
  } short_word_t;

  short_word_t     short_q[$];
  short_word_t     want;
  fsng_pkg::byte_t base_buf [fsng_pkg::BASE_MAX];
  fsng_pkg::byte_t ext_buf  [fsng_pkg::EXT_MAX];
  int              base_fill;
  int              ext_len;
  logic            dot_hit;

  initial begin
    errors     = 0;
    open_count = 0;
  end

  function automatic fsng_pkg::byte_t fold_char(input fsng_pkg::byte_t c);
    case (c)
      8'h00, 8'h09, 8'h0A, 8'h0D, 8'h20, 8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2E, 8'h2F,
      8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C:
        return fsng_pkg::CHAR_UNDER;
      default: begin
        if (c >= fsng_pkg::CHAR_LOW_A && c <= fsng_pkg::CHAR_LOW_Z) begin
          return c - fsng_pkg::CASE_GAP;
        end
        return c;
      end
    endcase
  endfunction

  task automatic clear_name();
    for (int i = 0; i < fsng_pkg::BASE_MAX; i++) base_buf[i] = fsng_pkg::CHAR_SPACE;
    for (int i = 0; i < fsng_pkg::EXT_MAX; i++) ext_buf[i] = fsng_pkg::CHAR_SPACE;
    base_fill = 0;
    ext_len   = 0;
    dot_hit   = 1'b0;
  endtask

  task automatic take_char(input fsng_pkg::byte_t c);
    if (!dot_hit && c == fsng_pkg::CHAR_DOT) begin
      dot_hit = 1'b1;
    end else if (!dot_hit) begin
      if (base_fill < fsng_pkg::BASE_MAX) base_buf[base_fill] = fold_char(c);
      if (base_fill <= fsng_pkg::BASE_MAX) base_fill++;
    end else if (ext_len < fsng_pkg::EXT_MAX) begin
      ext_buf[ext_len] = fold_char(c);
      ext_len++;
    end
  endtask

  task automatic predict_name();
    fsng_pkg::byte_t sum;
    fsng_pkg::byte_t b;
    short_word_t     w;
    sum = 8'h00;
    for (int i = 0; i < fsng_pkg::SN_LEN; i++) begin
      if (i >= fsng_pkg::BASE_MAX) begin
        b = ext_buf[i - fsng_pkg::BASE_MAX];
      end else if (base_fill > fsng_pkg::BASE_MAX && i >= fsng_pkg::BASE_KEEP) begin
        b = (i == fsng_pkg::BASE_KEEP) ? fsng_pkg::CHAR_TILDE : fsng_pkg::CHAR_ONE;
      end else begin
        b = base_buf[i];
      end
      sum = {sum[0], sum[7:1]} + b;
      w.short_char  = b;
      w.position    = fsng_pkg::pos_t'(i);
      w.last_result = (fsng_pkg::pos_t'(i) == fsng_pkg::POS_LAST);
      w.checksum    = w.last_result ? sum : 8'h00;
      short_q.push_back(w);
    end
    clear_name();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_name();
      short_q.delete();
    end else begin
      if (chars.valid && chars.ready) begin
        take_char(chars.name_char);
        if (chars.last_char) predict_name();
      end
      if (sname.valid && sname.ready) begin
        if (short_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word char=%h pos=%0d sum=%h last=%b", $time,
                   sname.short_char, sname.position, sname.checksum,
                   sname.last_result);
        end else begin
          want = short_q.pop_front();
          if (sname.short_char !== want.short_char) begin
            errors++;
            $display("%0t: short_char mismatch at pos %0d: expected %h, actual %h", $time,
                     want.position, want.short_char, sname.short_char);
          end
          if (sname.position !== want.position) begin
            errors++;
            $display("%0t: position mismatch: expected %0d, actual %0d", $time,
                     want.position, sname.position);
          end
          if (sname.checksum !== want.checksum) begin
            errors++;
            $display("%0t: checksum mismatch at pos %0d: expected %h, actual %h", $time,
                     want.position, want.checksum, sname.checksum);
          end
          if (sname.last_result !== want.last_result) begin
            errors++;
            $display("%0t: last_result mismatch at pos %0d: expected %b, actual %b", $time,
                     want.position, want.last_result, sname.last_result);
          end
        end
      end
    end
    open_count = short_q.size();
  end
endmodule

>>> tb/tb_top.sv
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_WORDS  = 410;
  localparam int CALM_FROM   = 350;

  logic clk;
  logic rst;
  int   errors;
  int   open_count;
  int   cycles;
  int   rand_words;
  int   stall_left;
  int   mode_left;
  bit   calm;
  bit   gappy;
  bit   sink_busy;

  fsng_pkg::byte_t odd_chars [21] = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h20, 8'h22, 8'h2A,
                                      8'h2B, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3C,
                                      8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C};

  fsng_char_if  chars ();
  fsng_short_if sname ();

  fat_short_name_generator i_dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .sname (sname)
  );

  fsng_checker i_check (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .sname      (sname),
    .errors     (errors),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      sink_busy = ($urandom_range(0, 2) != 0);
      mode_left = $urandom_range(10, 60);
    end else begin
      mode_left--;
    end
    if (calm || rst) begin
      sname.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      sname.ready <= 1'b0;
      stall_left--;
    end else if (sink_busy && $urandom_range(0, 3) == 0) begin
      sname.ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      sname.ready <= 1'b1;
    end
  end

  task automatic send_word(input fsng_pkg::byte_t c, input logic last);
    int gap;
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      chars.valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    chars.valid     <= 1'b1;
    chars.name_char <= c;
    chars.last_char <= last;
    do @(posedge clk); while (!chars.ready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(fsng_pkg::byte_t'(s[i]), i == s.len() - 1);
    end
  endtask

  function automatic fsng_pkg::byte_t pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return fsng_pkg::byte_t'($urandom_range(8'h61, 8'h7A));
      3:       return fsng_pkg::byte_t'($urandom_range(8'h30, 8'h5A));
      4:       return fsng_pkg::CHAR_DOT;
      5, 6:    return odd_chars[$urandom_range(0, 20)];
      7:       return fsng_pkg::byte_t'($urandom_range(8'h80, 8'hFF));
      default: return fsng_pkg::byte_t'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_random_name();
    int len;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
    gappy = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < len; i++) begin
      send_word(pick_char(), i == len - 1);
      rand_words++;
      if (rand_words > CALM_FROM) calm = 1'b1;
    end
  endtask

  initial begin
    rst             = 1'b1;
    calm            = 1'b0;
    gappy           = 1'b1;
    sink_busy       = 1'b1;
    stall_left      = 0;
    mode_left       = 0;
    rand_words      = 0;
    chars.valid     = 1'b0;
    chars.name_char = 8'h00;
    chars.last_char = 1'b0;
    sname.ready     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text("abcdefghi.t.xy");
    send_text(".c");
    send_text("Q9.");
    send_word(8'h00, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b1);
    send_text("*? ");

    while (rand_words < RAND_WORDS) send_random_name();
    chars.valid <= 1'b0;

    while (open_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && open_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
